>>> hw/rtl/kmi_pkg.sv
// Shared types and constants for the keyframe matrix interpolator.
package kmi_pkg;

  localparam int unsigned MAX_KEYS_DEF = 16;
  localparam int unsigned ELEMS        = 16;
  localparam int unsigned ELEM_W       = 4;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned DIV_STEPS    = FRAC_W + 1;
  localparam int unsigned STEP_W       = $clog2(DIV_STEPS);
  localparam int unsigned KCNT_W       = 5;

  typedef enum logic [1:0] {
    REQ_LOAD_TIME = 2'd0,
    REQ_LOAD_ELEM = 2'd1,
    REQ_QUERY     = 2'd2
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [3:0]         key_index;
    logic [3:0]         element_index;
    logic signed [31:0] load_time;
    logic signed [31:0] load_value;
    logic signed [31:0] query_time;
  } req_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               last;
  } res_t;

  typedef struct packed {
    logic time_we;
    logic mat_we;
    logic cap_query;
    logic t1_load;
    logic t2_load;
    logic weight_zero;
    logic div_prep;
    logic div_init;
    logic div_step;
    logic elem_valid;
  } cmd_t;

  typedef struct packed {
    logic t_le_rd;
    logic t_ge_rd;
  } stat_t;

endpackage

>>> hw/rtl/kmi_ctrl.sv
// Sequencer: segment search, divide steps and element issue.
module kmi_ctrl import kmi_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF,
  parameter int unsigned KW       = $clog2(MAX_KEYS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_type_e         req_type_i,
  input  logic [3:0]        key_index_i,
  input  logic [KCNT_W-1:0] key_count_i,
  input  stat_t             stat_i,
  output logic              busy_o,
  output cmd_t              cmd_o,
  output logic [KW-1:0]     time_raddr_o,
  output logic [KW-1:0]     seg_prev_o,
  output logic [KW-1:0]     seg_key_o,
  output logic [ELEM_W-1:0] elem_idx_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SCAN,
    S_DIV_PREP,
    S_DIV_INIT,
    S_DIV,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [KW-1:0]       i_q, i_d;
  logic [KW-1:0]       prev_q, prev_d;
  logic [KW-1:0]       key_q, key_d;
  logic [ELEM_W-1:0]   e_q, e_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [KW-1:0]       last_key;
  logic                key_ok;
  logic                found;

  always_comb begin
    if (key_count_i == '0) begin
      last_key = '0;
    end else if (32'(key_count_i) > MAX_KEYS) begin
      last_key = KW'(MAX_KEYS - 1);
    end else begin
      last_key = KW'(key_count_i - KCNT_W'(1));
    end
  end

  assign key_ok = 32'(key_index_i) < MAX_KEYS;
  assign found  = stat_i.t_le_rd || (i_q == last_key);

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    prev_d       = prev_q;
    key_d        = key_q;
    e_d          = e_q;
    step_d       = step_q;
    cmd_o        = '0;
    time_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_type_i)
            REQ_LOAD_TIME: cmd_o.time_we = key_ok;
            REQ_LOAD_ELEM: cmd_o.mat_we = key_ok;
            REQ_QUERY: begin
              cmd_o.cap_query = 1'b1;
              state_d         = S_CHK_FIRST;
            end
            default: ;
          endcase
        end
      end
      S_CHK_FIRST: begin
        time_raddr_o = last_key;
        if (stat_i.t_le_rd) begin
          prev_d            = '0;
          key_d             = '0;
          cmd_o.weight_zero = 1'b1;
          e_d               = '0;
          state_d           = S_EMIT;
        end else begin
          cmd_o.t1_load = 1'b1;
          state_d       = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        time_raddr_o = KW'(1);
        if (stat_i.t_ge_rd) begin
          prev_d            = last_key;
          key_d             = last_key;
          cmd_o.weight_zero = 1'b1;
          e_d               = '0;
          state_d           = S_EMIT;
        end else begin
          i_d     = KW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        time_raddr_o = i_q + KW'(1);
        if (found) begin
          cmd_o.t2_load = 1'b1;
          prev_d        = i_q - KW'(1);
          key_d         = i_q;
          state_d       = S_DIV_PREP;
        end else begin
          cmd_o.t1_load = 1'b1;
          i_d           = i_q + KW'(1);
        end
      end
      S_DIV_PREP: begin
        cmd_o.div_prep = 1'b1;
        state_d        = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          e_d     = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.elem_valid = 1'b1;
        e_d              = e_q + ELEM_W'(1);
        if (e_q == ELEM_W'(ELEMS - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      prev_q  <= '0;
      key_q   <= '0;
      e_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      prev_q  <= prev_d;
      key_q   <= key_d;
      e_q     <= e_d;
      step_q  <= step_d;
    end
  end

  assign busy_o     = state_q != S_IDLE;
  assign seg_prev_o = prev_q;
  assign seg_key_o  = key_q;
  assign elem_idx_o = e_q;

endmodule

>>> hw/rtl/kmi_dp.sv
// Datapath: key tables, weight divider and element blend pipeline.
module kmi_dp import kmi_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF,
  parameter int unsigned KW       = $clog2(MAX_KEYS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_t              req_i,
  input  cmd_t              cmd_i,
  input  logic [KW-1:0]     time_raddr_i,
  input  logic [KW-1:0]     seg_prev_i,
  input  logic [KW-1:0]     seg_key_i,
  input  logic [ELEM_W-1:0] elem_idx_i,
  output stat_t             stat_o,
  output logic              res_strobe_o,
  output res_t              res_o
);

  localparam int unsigned MAT_DEPTH = MAX_KEYS * ELEMS;
  localparam int unsigned MW        = KW + ELEM_W;

  logic signed [31:0] time_mem [MAX_KEYS];
  logic signed [31:0] mat_mem  [MAT_DEPTH];

  logic [KW-1:0]      wkey;
  logic signed [31:0] time_rd_q;
  logic signed [31:0] t_q, t1_q, t2_q;

  logic [31:0]        d_q, den_q;
  logic [32:0]        d_full, den_full;
  logic [49:0]        num_full;
  logic [32:0]        rem_q, rem_d;
  logic [33:0]        rem_sh, dvs;
  logic [FRAC_W-1:0]  nsh_q;
  logic [FRAC_W:0]    w_q;
  logic               q_bit;

  logic signed [31:0] p1_q, k1_q;
  logic [ELEM_W-1:0]  idx1_q, idx2_q;
  logic               v1_q, v2_q;
  logic signed [32:0] diff;
  logic signed [17:0] w_s;
  logic signed [50:0] prod_d, prod_q, rnd;
  logic signed [31:0] p2_q;

  assign wkey = KW'(req_i.key_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.time_we) begin
      time_mem[wkey] <= req_i.load_time;
    end
    time_rd_q <= time_mem[time_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_we) begin
      mat_mem[{wkey, req_i.element_index}] <= req_i.load_value;
    end
    p1_q <= mat_mem[MW'({seg_prev_i, elem_idx_i})];
    k1_q <= mat_mem[MW'({seg_key_i, elem_idx_i})];
  end

  assign stat_o.t_le_rd = t_q <= time_rd_q;
  assign stat_o.t_ge_rd = t_q >= time_rd_q;

  assign d_full   = {t_q[31], t_q} - {t1_q[31], t1_q};
  assign den_full = {t2_q[31], t2_q} - {t1_q[31], t1_q};
  assign num_full = {1'b0, d_q, 17'b0} + {18'b0, den_q};
  assign rem_sh   = {rem_q, nsh_q[FRAC_W-1]};
  assign dvs      = {1'b0, den_q, 1'b0};
  assign q_bit    = rem_sh >= dvs;
  assign rem_d    = q_bit ? 33'(rem_sh - dvs) : rem_sh[32:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_query) t_q <= req_i.query_time;
    if (cmd_i.t1_load) t1_q <= time_rd_q;
    if (cmd_i.t2_load) t2_q <= time_rd_q;
    if (cmd_i.div_prep) begin
      d_q   <= d_full[31:0];
      den_q <= den_full[31:0];
    end
    if (cmd_i.div_init) begin
      rem_q <= num_full[49:17];
      nsh_q <= num_full[FRAC_W:1];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      nsh_q <= {nsh_q[FRAC_W-2:0], 1'b0};
    end
    if (cmd_i.weight_zero) begin
      w_q <= '0;
    end else if (cmd_i.div_step) begin
      w_q <= {w_q[FRAC_W-1:0], q_bit};
    end
  end

  assign w_s    = $signed({1'b0, w_q});
  assign diff   = $signed({k1_q[31], k1_q}) - $signed({p1_q[31], p1_q});
  assign prod_d = w_s * diff;
  assign rnd    = prod_q + 51'sd32768;

  always_ff @(posedge clk_i) begin
    idx1_q          <= elem_idx_i;
    prod_q          <= prod_d;
    p2_q            <= p1_q;
    idx2_q          <= idx1_q;
    res_o.out_index <= idx2_q;
    res_o.out_value <= p2_q + rnd[47:16];
    res_o.last      <= idx2_q == ELEM_W'(ELEMS - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      res_strobe_o <= 1'b0;
    end else begin
      v1_q         <= cmd_i.elem_valid;
      v2_q         <= v1_q;
      res_strobe_o <= v2_q;
    end
  end

endmodule

>>> hw/rtl/keyframe_matrix_interpolator.sv
// Top level: keyframe matrix interpolator with APB register port.
//
//  channel   signals                              direction  beat taken when
//  request   start, busy, req_i                   in         start & !busy
//  result    res_strobe_o, res_o                  out        res_strobe_o
//  config    psel penable pwrite paddr pwdata     in         psel & penable & pwrite & pready
//
// Loads leave busy low. A query at or before the first key, or at or after the last
// key in use, holds busy through one or both boundary checks and the element beats; for a
// segment ending at key k it also holds busy through a search up to key k, two divider
// setup steps and 17 bit-serial divide steps. The 16 element beats issue one per cycle
// from the dual-read matrix memory. Results pass the matrix read, product and output
// registers, one beat per cycle; the receiver cannot stall.
// Reset clears control and sets key_count to 1; the key tables stay undefined.
module keyframe_matrix_interpolator import kmi_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        res_strobe_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned KW = $clog2(MAX_KEYS);
  localparam logic REG_KEY_COUNT = 1'b0;

  logic [KCNT_W-1:0] key_count_q;
  cmd_t              cmd;
  stat_t             stat;
  logic [KW-1:0]     time_raddr;
  logic [KW-1:0]     seg_prev;
  logic [KW-1:0]     seg_key;
  logic [ELEM_W-1:0] elem_idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEY_COUNT) ? {{(32 - KCNT_W){1'b0}}, key_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KCNT_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == REG_KEY_COUNT) begin
      key_count_q <= pwdata[KCNT_W-1:0];
    end
  end

  kmi_ctrl #(
    .MAX_KEYS(MAX_KEYS),
    .KW      (KW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_i.req_type),
    .key_index_i (req_i.key_index),
    .key_count_i (key_count_q),
    .stat_i      (stat),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .time_raddr_o(time_raddr),
    .seg_prev_o  (seg_prev),
    .seg_key_o   (seg_key),
    .elem_idx_o  (elem_idx)
  );

  kmi_dp #(
    .MAX_KEYS(MAX_KEYS),
    .KW      (KW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .time_raddr_i(time_raddr),
    .seg_prev_i  (seg_prev),
    .seg_key_i   (seg_key),
    .elem_idx_i  (elem_idx),
    .stat_o      (stat),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

`ifndef ASSERT_OFF
  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.last == (res_o.out_index == ELEM_W'(ELEMS - 1))))
    else $error("last flag does not match element index");

  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.out_index != '0 |-> $past(res_strobe_o))
    else $error("gap inside a result run");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == REQ_QUERY |=> busy)
    else $error("query accepted without going busy");
`endif

endmodule

>>> tb/keyframe_matrix_interpolator_tb.sv
// Self-checking bench for the keyframe matrix interpolator: table loads, key counts, queries.
module keyframe_matrix_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmi_pkg::*;

  localparam logic [2:0]  KEY_COUNT_ADDR = 3'd0;
  localparam logic [2:0]  UNUSED_ADDR    = 3'd4;
  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned MAX_PRINTS     = 40;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  req_t        req_i   = '0;
  logic        res_strobe_o;
  res_t        res_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic signed [31:0] key_time_q [MAX_KEYS_DEF];
  logic signed [31:0] key_elem_q [MAX_KEYS_DEF][ELEMS];
  logic [KCNT_W-1:0]  key_count_q = 5'd1;
  res_t               expected_elems [$];

  int unsigned mismatch_count = 0;
  int unsigned query_count    = 0;
  int unsigned load_count     = 0;
  int unsigned ignored_count  = 0;
  int unsigned beat_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  bit          gapless        = 1'b0;

  keyframe_matrix_interpolator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Expected 16-beat matrix run for a query against the current table.
  function automatic void predict_matrix_run(input logic signed [31:0] qt);
    int unsigned cnt, seg, lo;
    longint t, span, w, p, k, v;
    res_t r;
    cnt = (key_count_q == 0) ? 1 :
          ((key_count_q > MAX_KEYS_DEF) ? MAX_KEYS_DEF : key_count_q);
    t = qt;
    w = 0;
    if (t <= key_time_q[0]) begin
      seg = 0;
      lo  = 0;
    end else if (t >= key_time_q[cnt-1]) begin
      seg = cnt - 1;
      lo  = seg;
    end else begin
      seg = 1;
      while (seg < cnt - 1 && t > key_time_q[seg]) seg++;
      lo   = seg - 1;
      span = longint'(key_time_q[seg]) - longint'(key_time_q[lo]);
      w    = ((t - longint'(key_time_q[lo])) * 65536 * 2 + span) / (span * 2);
      if (w < 0) w = 0;
      if (w > 65536) w = 65536;
    end
    for (int e = 0; e < ELEMS; e++) begin
      p = key_elem_q[lo][e];
      k = key_elem_q[seg][e];
      v = p + ((w * (k - p) + 32768) >>> 16);
      r.out_index = 4'(e);
      r.out_value = v[31:0];
      r.last      = (e == ELEMS - 1);
      expected_elems.insert(expected_elems.size(), r);
    end
  endfunction

  function automatic void apply_req(input req_t r);
    case (r.req_type)
      REQ_LOAD_TIME: begin
        key_time_q[r.key_index] = r.load_time;
        load_count++;
      end
      REQ_LOAD_ELEM: begin
        key_elem_q[r.key_index][r.element_index] = r.load_value;
        load_count++;
      end
      REQ_QUERY: begin
        predict_matrix_run(r.query_time);
        query_count++;
      end
      default: ignored_count++;
    endcase
  endfunction

  function automatic req_t make_req(input req_type_e kind, input logic [3:0] key,
                                    input logic [3:0] elem, input logic [31:0] val);
    req_t r;
    r.req_type      = kind;
    r.key_index     = key;
    r.element_index = elem;
    r.load_time     = $urandom;
    r.load_value    = $urandom;
    r.query_time    = $urandom;
    case (kind)
      REQ_LOAD_TIME: r.load_time  = val;
      REQ_LOAD_ELEM: r.load_value = val;
      REQ_QUERY:     r.query_time = val;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_strobe_o) begin
      beat_count++;
      if (expected_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected beat index %0d value %h",
                                  res_o.out_index, res_o.out_value));
      end else begin
        want = expected_elems.pop_front();
        if (res_o.out_index !== want.out_index)
          report_mismatch($sformatf("index got %0d want %0d", res_o.out_index,
                                    want.out_index));
        if (res_o.out_value !== want.out_value)
          report_mismatch($sformatf("value at index %0d got %h want %h", want.out_index,
                                    res_o.out_value, want.out_value));
        if (res_o.last !== want.last)
          report_mismatch($sformatf("last at index %0d got %b want %b", want.out_index,
                                    res_o.last, want.last));
      end
    end
  end

  task automatic send_req(input req_t r);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!gapless)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    // busy is stable at the falling edge; the next rising edge takes the beat
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    apply_req(r);
  endtask

  task automatic settle(input int unsigned tail);
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_elems.size() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == KEY_COUNT_ADDR) key_count_q = data[KCNT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_fill_table();
    logic signed [31:0] tv;
    logic [31:0]        ev;
    apb_write(KEY_COUNT_ADDR, 32'd16);
    for (int k = 0; k < MAX_KEYS_DEF; k++) begin
      if (k == 0) tv = 32'sh8000_0000;
      else if (k == MAX_KEYS_DEF - 1) tv = 32'sh7fff_ffff;
      else tv = (k - 8) * 32'sh0100_0000;
      send_req(make_req(REQ_LOAD_TIME, 4'(k), 4'($urandom), tv));
      for (int e = 0; e < ELEMS; e++) begin
        ev = $urandom;
        if (k < 2 && e < 2) ev = ((k ^ e) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
        send_req(make_req(REQ_LOAD_ELEM, 4'(k), 4'(e), ev));
      end
    end
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_boundaries();
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'h8000_0000));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[0] + 1));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'hC000_0000));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'h7fff_ffff));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[15] - 1));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[5]));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[4] + 1));
    // half weight, so odd element deltas land on a rounding tie
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom),
                      key_time_q[5] + 32'sh0080_0000));
    send_req(make_req(req_type_e'(REQ_UNUSED), 4'($urandom), 4'($urandom), $urandom));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[6] - 1));
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_key_counts();
    apb_write(KEY_COUNT_ADDR, 32'd0);
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'hC000_0000));
    settle(SETTLE_CYCLES);
    apb_write(KEY_COUNT_ADDR, 32'd1);
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'h0000_1234));
    settle(SETTLE_CYCLES);
    apb_write(KEY_COUNT_ADDR, 32'd2);
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'hC000_0000));
    settle(SETTLE_CYCLES);
    apb_write(KEY_COUNT_ADDR, 32'd31);
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), 32'h7fff_fffe));
    settle(SETTLE_CYCLES);
    apb_write(KEY_COUNT_ADDR, 32'd16);
    apb_write(UNUSED_ADDR, 32'd3);
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[14] + 1));
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_unordered_times();
    send_req(make_req(REQ_LOAD_TIME, 4'd5, 4'($urandom), key_time_q[3] - 5));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), -3 * 32'sh0100_0000));
    send_req(make_req(REQ_QUERY, 4'($urandom), 4'($urandom), key_time_q[4] - 7));
    send_req(make_req(REQ_LOAD_TIME, 4'd5, 4'($urandom), -3 * 32'sh0100_0000));
    settle(SETTLE_CYCLES);
  endtask

  task automatic test_random();
    int unsigned        k, pick;
    logic signed [31:0] v;
    req_t               r;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       apb_write(KEY_COUNT_ADDR, 32'd16);
        1:       apb_write(KEY_COUNT_ADDR, $urandom_range(0, 31));
        2:       apb_write(KEY_COUNT_ADDR, $urandom_range(2, 16));
        default: apb_write(KEY_COUNT_ADDR, 32'd31);
      endcase
      gapless = (ph == 2);
      for (int n = 0; n < 18; n++) begin
        k    = $urandom_range(0, MAX_KEYS_DEF - 1);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = key_time_q[k];
            2:       v = key_time_q[k] + int'($urandom_range(0, 64)) - 32;
            default: v = 32'((longint'(key_time_q[k]) +
                              longint'(key_time_q[(k + 1) % MAX_KEYS_DEF])) / 2);
          endcase
          r = make_req(REQ_QUERY, 4'($urandom), 4'($urandom), v);
        end else if (pick < 80) begin
          r = make_req(REQ_LOAD_ELEM, 4'(k), 4'($urandom), $urandom);
        end else if (pick < 95) begin
          if ($urandom_range(0, 5) == 0) v = $urandom;
          else v = key_time_q[k] + int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
          r = make_req(REQ_LOAD_TIME, 4'(k), 4'($urandom), v);
        end else begin
          r = make_req(req_type_e'(REQ_UNUSED), 4'($urandom), 4'($urandom), $urandom);
        end
        send_req(r);
      end
      settle(SETTLE_CYCLES);
    end
    gapless = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_table();
    test_boundaries();
    test_key_counts();
    test_unordered_times();
    test_random();
    settle(DRAIN_CYCLES);
    $display("Run covered %0d loads, %0d queries and %0d ignored requests; %0d beats checked.",
             load_count, query_count, ignored_count, beat_count);
    $display("Key counts 0, 1, 2, 16, 31 and random, unordered times, gapped and gapless bursts.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
